FILE: sv/fcl_pkg.sv
package fcl_pkg;

	// Default sizes of the table and of the longest reported chain.
	localparam int TABLE_ENTRIES_DEF = 128;
	localparam int MAX_CHAIN_DEF     = 64;

	// Fixed field widths.
	localparam int WORD_W  = 32;
	localparam int INDEX_W = 7;
	localparam int POS_W   = 6;
	localparam int STAT_W  = 2;
	localparam int REG_W   = 3;

	// Table value that marks the end of a chain.
	localparam logic [WORD_W-1:0] END_MARK = 32'h0FFF_FFFF;

	// Function codes of an input beat.
	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_FOLLOW = 1'b1;

	// Result status codes.
	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_END   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;
	localparam logic [STAT_W-1:0] STAT_TRUNC = 2'd3;

	// Configuration register indexes.
	localparam logic [REG_W-1:0] REG_VOLUME_START     = 3'd0;
	localparam logic [REG_W-1:0] REG_RESERVED_SECTORS = 3'd1;
	localparam logic [REG_W-1:0] REG_TABLE_COPIES     = 3'd2;
	localparam logic [REG_W-1:0] REG_TABLE_SECTORS    = 3'd3;
	localparam logic [REG_W-1:0] REG_CLUSTER_SECTORS  = 3'd4;

	// Configuration register reset values.
	localparam logic [31:0] VOLUME_START_RST     = 32'd2048;
	localparam logic [15:0] RESERVED_SECTORS_RST = 16'd32;
	localparam logic [7:0]  TABLE_COPIES_RST     = 8'd2;
	localparam logic [31:0] TABLE_SECTORS_RST    = 32'd0;
	localparam logic [7:0]  CLUSTER_SECTORS_RST  = 8'd1;

	// Volume geometry as held in the configuration registers.
	typedef struct packed {
		logic [31:0] volume_start;
		logic [15:0] reserved_sectors;
		logic [7:0]  table_copies;
		logic [31:0] table_sectors;
		logic [7:0]  cluster_sectors;
	} cfg_t;

	// Load strobes for the address unit.
	typedef struct packed {
		logic load_prod;
		logic load_base;
		logic load_off;
	} addr_ctl_t;

endpackage

FILE: sv/fcl_table.sv
module fcl_table #(
	parameter int ENTRIES = fcl_pkg::TABLE_ENTRIES_DEF,
	parameter int IDX_W   = $clog2(ENTRIES)
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [IDX_W-1:0]           wr_idx,
	input  logic [fcl_pkg::WORD_W-1:0] wr_data,
	input  logic                       rd_en,
	input  logic [IDX_W-1:0]           rd_idx,
	output logic [fcl_pkg::WORD_W-1:0] rd_data
);
	import fcl_pkg::*;

	logic [WORD_W-1:0] table_q [ENTRIES];
	logic [WORD_W-1:0] rd_data_q;

	// Single write port, single read port with registered data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_q[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= table_q[rd_idx];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: sv/fcl_addr.sv
module fcl_addr (
	input  logic                       clk,
	input  fcl_pkg::cfg_t              cfg,
	input  fcl_pkg::addr_ctl_t         ctl,
	input  logic [fcl_pkg::WORD_W-1:0] cluster,
	output logic [fcl_pkg::WORD_W-1:0] sector_addr
);
	import fcl_pkg::*;

	logic [39:0]       prod_full;
	logic [39:0]       off_full;
	logic [WORD_W-1:0] cluster_rel;
	logic [WORD_W-1:0] prod_q;
	logic [WORD_W-1:0] base_q;
	logic [WORD_W-1:0] off_s1;

	// Both products are 8 by 32 bits; only the low word is kept.
	assign prod_full   = 40'(cfg.table_copies) * 40'(cfg.table_sectors);
	assign cluster_rel = cluster - 32'd2;
	assign off_full    = 40'(cluster_rel) * 40'(cfg.cluster_sectors);

	// The base is built once per chain, the offset once per link.
	always_ff @(posedge clk) begin
		if (ctl.load_prod) begin
			prod_q <= prod_full[WORD_W-1:0];
		end
		if (ctl.load_base) begin
			base_q <= cfg.volume_start + 32'(cfg.reserved_sectors) + prod_q;
		end
		if (ctl.load_off) begin
			off_s1 <= off_full[WORD_W-1:0];
		end
	end

	assign sector_addr = base_q + off_s1;

endmodule

FILE: sv/fat_cluster_chain_to_lba.sv
// Table write: the acknowledge beat appears in the cycle after start; busy stays low.
// Chain follow: after start the walk runs S_PROD and S_BASE once, then S_READ and
// S_EMIT for each link; busy stays high for the whole walk of at most MAX_CHAIN results,
// with one table read and one offset multiply per link; results cannot be stalled.
// Reset (arst_n low) loads the default geometry and returns to idle; the table
// itself is not cleared and must be written before it is followed.
module fat_cluster_chain_to_lba #(
	parameter int TABLE_ENTRIES = fcl_pkg::TABLE_ENTRIES_DEF,
	parameter int MAX_CHAIN     = fcl_pkg::MAX_CHAIN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Command channel
	input  logic                        start,
	output logic                        busy,
	input  logic                        func,
	input  logic [fcl_pkg::INDEX_W-1:0] entry_index,
	input  logic [fcl_pkg::WORD_W-1:0]  entry_value,
	input  logic [fcl_pkg::WORD_W-1:0]  start_cluster,
	// Result channel
	output logic                        result_valid,
	output logic [fcl_pkg::WORD_W-1:0]  sector_address,
	output logic [fcl_pkg::POS_W-1:0]   chain_position,
	output logic [fcl_pkg::STAT_W-1:0]  status,
	output logic                        last,
	// Configuration channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [fcl_pkg::REG_W-1:0]   cfg_index,
	input  logic [fcl_pkg::WORD_W-1:0]  cfg_data
);
	import fcl_pkg::*;

	localparam int IDX_W = $clog2(TABLE_ENTRIES);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_PROD = 5'b00010,
		S_BASE = 5'b00100,
		S_READ = 5'b01000,
		S_EMIT = 5'b10000
	} state_t;

	state_t            state_q;
	cfg_t              cfg_q;
	addr_ctl_t         addr_ctl;
	logic [WORD_W-1:0] cluster_q;
	logic [POS_W-1:0]  pos_q;
	logic [WORD_W-1:0] next_cluster;
	logic [WORD_W-1:0] link_addr;
	logic [WORD_W-1:0] entry_ext;
	logic              accept;
	logic              accept_write;
	logic              accept_follow;
	logic              entry_in_range;
	logic              cluster_in_range;
	logic              chain_end;
	logic              at_limit;
	logic              tbl_wr_en;
	logic              tbl_rd_en;

	logic              result_valid_q;
	logic [WORD_W-1:0] sector_address_q;
	logic [POS_W-1:0]  chain_position_q;
	logic [STAT_W-1:0] status_q;
	logic              last_q;

	// Handshake decode. Geometry is taken only while no walk runs and no
	// command arrives, so a walk always sees one consistent geometry.
	assign busy          = (state_q != S_IDLE);
	assign accept        = start && !busy;
	assign accept_write  = accept && (func == FUNC_WRITE);
	assign accept_follow = accept && (func == FUNC_FOLLOW);
	assign cfg_ready     = !busy && !start;

	// Range checks against the table size.
	assign entry_ext        = 32'(entry_index);
	assign entry_in_range   = (entry_ext < 32'(TABLE_ENTRIES));
	assign cluster_in_range = (cluster_q < 32'(TABLE_ENTRIES));
	assign chain_end        = (next_cluster == END_MARK) || (next_cluster == '0);
	assign at_limit         = (pos_q == POS_W'(MAX_CHAIN - 1));

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.volume_start     <= VOLUME_START_RST;
			cfg_q.reserved_sectors <= RESERVED_SECTORS_RST;
			cfg_q.table_copies     <= TABLE_COPIES_RST;
			cfg_q.table_sectors    <= TABLE_SECTORS_RST;
			cfg_q.cluster_sectors  <= CLUSTER_SECTORS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_VOLUME_START:     cfg_q.volume_start     <= cfg_data;
				REG_RESERVED_SECTORS: cfg_q.reserved_sectors <= cfg_data[15:0];
				REG_TABLE_COPIES:     cfg_q.table_copies     <= cfg_data[7:0];
				REG_TABLE_SECTORS:    cfg_q.table_sectors    <= cfg_data;
				REG_CLUSTER_SECTORS:  cfg_q.cluster_sectors  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Table memory. Writes happen only while idle and reads only during a
	// walk, so the two ports never touch the same entry in one cycle.
	assign tbl_wr_en = accept_write && entry_in_range;
	assign tbl_rd_en = (state_q == S_READ);

	fcl_table #(
		.ENTRIES (TABLE_ENTRIES),
		.IDX_W   (IDX_W)
	) u_table (
		.clk     (clk),
		.wr_en   (tbl_wr_en),
		.wr_idx  (entry_ext[IDX_W-1:0]),
		.wr_data (entry_value),
		.rd_en   (tbl_rd_en),
		.rd_idx  (cluster_q[IDX_W-1:0]),
		.rd_data (next_cluster)
	);

	// Address arithmetic.
	assign addr_ctl.load_prod = (state_q == S_PROD);
	assign addr_ctl.load_base = (state_q == S_BASE);
	assign addr_ctl.load_off  = (state_q == S_READ);

	fcl_addr u_addr (
		.clk         (clk),
		.cfg         (cfg_q),
		.ctl         (addr_ctl),
		.cluster     (cluster_q),
		.sector_addr (link_addr)
	);

	// Walk sequencer: S_READ reads the table and S_EMIT decides, for each link.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept_follow) begin
						state_q <= S_PROD;
					end
				end
				S_PROD: state_q <= S_BASE;
				S_BASE: state_q <= S_READ;
				S_READ: state_q <= S_EMIT;
				S_EMIT: begin
					if (!cluster_in_range || chain_end || at_limit) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_READ;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Current cluster and its position in the chain.
	always_ff @(posedge clk) begin
		if (accept_follow) begin
			cluster_q <= start_cluster;
			pos_q     <= '0;
		end else if (state_q == S_EMIT) begin
			cluster_q <= next_cluster;
			pos_q     <= pos_q + POS_W'(1);
		end
	end

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= accept_write || (state_q == S_EMIT);
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (accept_write) begin
			sector_address_q <= '0;
			chain_position_q <= '0;
			status_q         <= entry_in_range ? STAT_OK : STAT_RANGE;
			last_q           <= 1'b1;
		end else if (state_q == S_EMIT) begin
			sector_address_q <= link_addr;
			chain_position_q <= pos_q;
			if (!cluster_in_range) begin
				status_q <= STAT_RANGE;
				last_q   <= 1'b1;
			end else if (chain_end) begin
				status_q <= STAT_END;
				last_q   <= 1'b1;
			end else if (at_limit) begin
				status_q <= STAT_TRUNC;
				last_q   <= 1'b1;
			end else begin
				status_q <= STAT_OK;
				last_q   <= 1'b0;
			end
		end
	end

	assign result_valid   = result_valid_q;
	assign sector_address = sector_address_q;
	assign chain_position = chain_position_q;
	assign status         = status_q;
	assign last           = last_q;

`ifndef NO_ASSERTIONS
	// A beat that is not the last one leaves the walk running.
	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !last_q |-> busy)
		else $error("chain beat without last while sequencer idle");

	// Only the final beat of an item carries a non-ok status.
	a_status_final: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !last_q |-> status_q == STAT_OK)
		else $error("non-ok status on a beat that is not last");

	// Positions never pass the chain limit.
	a_pos_limit: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> chain_position_q <= POS_W'(MAX_CHAIN - 1))
		else $error("chain position beyond limit");

	// A follow command starts the base computation in the next cycle.
	a_follow_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept_follow |=> state_q == S_PROD)
		else $error("follow command not started");

	// The table is written only while no walk is running.
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_wr_en |-> !tbl_rd_en && !busy)
		else $error("table write during a walk");
`endif

endmodule
